@@ rtl/eres_pkg.sv @@
`default_nettype none

package eres_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ESC_CONTROL    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ESC_TRIP_LEVEL = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ESC_PERIOD     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ESC_HOLDOFF    = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SAFE_ENABLE    = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SAFE_TRIP_LEVEL = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SAFE_PERIOD    = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SAFE_DWELL     = 4'd7;

    localparam logic [3:0]  RST_ESC_CONTROL     = 4'd0;
    localparam logic [15:0] RST_ESC_TRIP_LEVEL  = 16'd3;
    localparam logic [15:0] RST_ESC_PERIOD      = 16'd3000;
    localparam logic [15:0] RST_ESC_HOLDOFF     = 16'd6000;
    localparam logic        RST_SAFE_ENABLE     = 1'b0;
    localparam logic [15:0] RST_SAFE_TRIP_LEVEL = 16'd10;
    localparam logic [15:0] RST_SAFE_PERIOD     = 16'd5000;
    localparam logic [15:0] RST_SAFE_DWELL      = 16'd30000;

    // Bit positions inside esc_control.
    localparam int ESC_EN_BIT      = 3;
    localparam int ESC_ERR_BIT     = 0;
    localparam int ESC_TIMEOUT_BIT = 1;
    localparam int ESC_RULE_BIT    = 2;

    typedef struct packed {
        logic [3:0]  esc_control;
        logic [15:0] esc_trip_level;
        logic [15:0] esc_period;
        logic [15:0] esc_holdoff;
        logic        safe_enable;
        logic [15:0] safe_trip_level;
        logic [15:0] safe_period;
        logic [15:0] safe_dwell;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [31:0] error_total;
        logic [31:0] timeout_total;
        logic [31:0] rule_total;
    } sample_t;

    typedef struct packed {
        logic        esc_fired;
        logic [31:0] esc_delta_errors;
        logic [31:0] esc_delta_timeouts;
        logic [31:0] esc_delta_rules;
        logic [31:0] esc_fire_total;
        logic        safe_entered;
        logic        safe_exited;
        logic        safe_is_active;
        logic [31:0] safe_delta_errors;
        logic [31:0] safe_delta_timeouts;
        logic [31:0] safe_delta_escalations;
        logic [31:0] safe_fire_total;
    } report_t;

endpackage

`default_nettype wire

@@ rtl/error_rate_escalation_supervisor.sv @@
// An accepted sample request lands in the input register, then steps into the result
// register and shows up as a report request; a report stall holds it back in between.
// Throughput: one sample per cycle unless the report side stalls; the supervisor state
// updates in one pass as a sample moves from the input register to the result register.
// Reset: rst_n clears all supervisor state to zero and the config registers to their defaults.
`default_nettype none

module error_rate_escalation_supervisor #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             sample_valid,
    output logic                                  sample_stall,
    input  wire eres_pkg::sample_t                sample,
    output logic                                  report_valid,
    input  wire logic                             report_stall,
    output eres_pkg::report_t                     report,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [eres_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [eres_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import eres_pkg::*;

    localparam int EXT_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    cfg_t cfg;

    assign cfg_ready = 1'b1;

    eres_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Handshake and pipeline registers.
    logic    in_valid_reg;
    sample_t in_reg;
    logic    report_valid_reg;
    report_t report_reg;
    logic    advance;
    logic    in_load;

    assign advance      = !report_valid_reg || !report_stall;
    assign sample_stall = in_valid_reg && !advance;
    assign in_load      = sample_valid && !sample_stall;

    // Supervisor state.
    logic [31:0]            esc_last_eval_reg, esc_last_eval_next;
    logic [31:0]            esc_last_fire_reg, esc_last_fire_next;
    logic [31:0]            esc_base_err_reg, esc_base_err_next;
    logic [31:0]            esc_base_to_reg, esc_base_to_next;
    logic [31:0]            esc_base_rule_reg, esc_base_rule_next;
    logic [COUNT_WIDTH-1:0] esc_count_reg, esc_count_next;
    logic                   safe_active_reg, safe_active_next;
    logic [31:0]            safe_enter_reg, safe_enter_next;
    logic [31:0]            safe_last_eval_reg, safe_last_eval_next;
    logic [31:0]            safe_base_err_reg, safe_base_err_next;
    logic [31:0]            safe_base_to_reg, safe_base_to_next;
    logic [COUNT_WIDTH-1:0] safe_base_esc_reg, safe_base_esc_next;
    logic [COUNT_WIDTH-1:0] safe_count_reg, safe_count_next;

    // Step logic.
    logic [31:0]            esc_de, esc_dt, esc_dr;
    logic                   esc_eval, esc_hit, esc_fire;
    logic                   safe_exit, safe_go, safe_eval, safe_enter;
    logic [31:0]            safe_last_eval_eff, safe_base_err_eff, safe_base_to_eff;
    logic [COUNT_WIDTH-1:0] safe_base_esc_eff, safe_desc;
    logic [EXT_W-1:0]       safe_desc_ext, esc_count_ext, safe_count_ext;
    logic                   safe_desc_big;
    logic [33:0]            safe_score;
    logic [31:0]            safe_de, safe_dt;
    report_t                report_next;

    always_comb
    begin
        esc_eval = cfg.esc_control[ESC_EN_BIT]
            && ((in_reg.now_ms - esc_last_eval_reg) >= {16'd0, cfg.esc_period});
        esc_de = in_reg.error_total - esc_base_err_reg;
        esc_dt = in_reg.timeout_total - esc_base_to_reg;
        esc_dr = in_reg.rule_total - esc_base_rule_reg;
        esc_hit = (cfg.esc_control[ESC_ERR_BIT] && (esc_de >= {16'd0, cfg.esc_trip_level}))
            || (cfg.esc_control[ESC_TIMEOUT_BIT] && (esc_dt >= {16'd0, cfg.esc_trip_level}))
            || (cfg.esc_control[ESC_RULE_BIT] && (esc_dr >= {16'd0, cfg.esc_trip_level}));
        esc_fire = esc_eval && esc_hit
            && ((in_reg.now_ms - esc_last_fire_reg) >= {16'd0, cfg.esc_holdoff});

        esc_count_next     = esc_fire ? esc_count_reg + COUNT_WIDTH'(1) : esc_count_reg;
        esc_last_fire_next = esc_fire ? in_reg.now_ms : esc_last_fire_reg;
        esc_last_eval_next = esc_eval ? in_reg.now_ms : esc_last_eval_reg;
        esc_base_err_next  = esc_eval ? in_reg.error_total : esc_base_err_reg;
        esc_base_to_next   = esc_eval ? in_reg.timeout_total : esc_base_to_reg;
        esc_base_rule_next = esc_eval ? in_reg.rule_total : esc_base_rule_reg;

        // An exit re-baselines first; the window check then runs on the fresh baseline.
        safe_exit = cfg.safe_enable && safe_active_reg
            && ((in_reg.now_ms - safe_enter_reg) >= {16'd0, cfg.safe_dwell});
        safe_go = !safe_active_reg || safe_exit;
        safe_last_eval_eff = safe_exit ? in_reg.now_ms : safe_last_eval_reg;
        safe_base_err_eff  = safe_exit ? in_reg.error_total : safe_base_err_reg;
        safe_base_to_eff   = safe_exit ? in_reg.timeout_total : safe_base_to_reg;
        safe_base_esc_eff  = safe_exit ? esc_count_next : safe_base_esc_reg;

        safe_eval = cfg.safe_enable && safe_go
            && ((in_reg.now_ms - safe_last_eval_eff) >= {16'd0, cfg.safe_period});
        safe_de = in_reg.error_total - safe_base_err_eff;
        safe_dt = in_reg.timeout_total - safe_base_to_eff;
        safe_desc = esc_count_next - safe_base_esc_eff;
        safe_desc_ext = EXT_W'(safe_desc);
        // A fire delta beyond 32 bits trips safe mode on an evaluation whatever the score.
        safe_desc_big = safe_desc_ext > EXT_W'(32'hFFFF_FFFF);
        safe_score = 34'(safe_de) + 34'(safe_dt) + 34'(safe_desc_ext[31:0]);
        safe_enter = safe_eval
            && (safe_desc_big || (safe_score >= {18'd0, cfg.safe_trip_level}));

        if (safe_enter)
        begin
            safe_active_next = 1'b1;
        end
        else if (safe_exit)
        begin
            safe_active_next = 1'b0;
        end
        else
        begin
            safe_active_next = safe_active_reg;
        end
        safe_enter_next     = safe_enter ? in_reg.now_ms : safe_enter_reg;
        safe_count_next     = safe_enter ? safe_count_reg + COUNT_WIDTH'(1) : safe_count_reg;
        safe_last_eval_next = (safe_exit || safe_eval) ? in_reg.now_ms : safe_last_eval_reg;
        safe_base_err_next  = (safe_exit || safe_eval) ? in_reg.error_total
                                                       : safe_base_err_reg;
        safe_base_to_next   = (safe_exit || safe_eval) ? in_reg.timeout_total
                                                       : safe_base_to_reg;
        safe_base_esc_next  = (safe_exit || safe_eval) ? esc_count_next : safe_base_esc_reg;

        esc_count_ext  = EXT_W'(esc_count_next);
        safe_count_ext = EXT_W'(safe_count_next);

        report_next.esc_fired              = esc_fire;
        report_next.esc_delta_errors       = esc_eval ? esc_de : 32'd0;
        report_next.esc_delta_timeouts     = esc_eval ? esc_dt : 32'd0;
        report_next.esc_delta_rules        = esc_eval ? esc_dr : 32'd0;
        report_next.esc_fire_total         = esc_count_ext[31:0];
        report_next.safe_entered           = safe_enter;
        report_next.safe_exited            = safe_exit;
        report_next.safe_is_active         = safe_active_next;
        report_next.safe_delta_errors      = safe_eval ? safe_de : 32'd0;
        report_next.safe_delta_timeouts    = safe_eval ? safe_dt : 32'd0;
        report_next.safe_delta_escalations = safe_eval ? safe_desc_ext[31:0] : 32'd0;
        report_next.safe_fire_total        = safe_count_ext[31:0];
    end

    logic step;
    assign step = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            report_valid_reg   <= 1'b0;
            esc_last_eval_reg  <= '0;
            esc_last_fire_reg  <= '0;
            esc_base_err_reg   <= '0;
            esc_base_to_reg    <= '0;
            esc_base_rule_reg  <= '0;
            esc_count_reg      <= '0;
            safe_active_reg    <= 1'b0;
            safe_enter_reg     <= '0;
            safe_last_eval_reg <= '0;
            safe_base_err_reg  <= '0;
            safe_base_to_reg   <= '0;
            safe_base_esc_reg  <= '0;
            safe_count_reg     <= '0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                report_valid_reg <= in_valid_reg;
            end
            if (step)
            begin
                esc_last_eval_reg  <= esc_last_eval_next;
                esc_last_fire_reg  <= esc_last_fire_next;
                esc_base_err_reg   <= esc_base_err_next;
                esc_base_to_reg    <= esc_base_to_next;
                esc_base_rule_reg  <= esc_base_rule_next;
                esc_count_reg      <= esc_count_next;
                safe_active_reg    <= safe_active_next;
                safe_enter_reg     <= safe_enter_next;
                safe_last_eval_reg <= safe_last_eval_next;
                safe_base_err_reg  <= safe_base_err_next;
                safe_base_to_reg   <= safe_base_to_next;
                safe_base_esc_reg  <= safe_base_esc_next;
                safe_count_reg     <= safe_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_reg <= sample;
        end
        if (step)
        begin
            report_reg <= report_next;
        end
    end

    assign report_valid = report_valid_reg;
    assign report       = report_reg;

    // The input register only holds a request back while the result register is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (in_valid_reg && report_valid_reg && report_stall))
        else $error("sample stalled without a blocked report");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step && esc_fire) |=> (esc_count_reg == $past(esc_count_reg) + COUNT_WIDTH'(1)))
        else $error("escalation fire did not advance the fire count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (report_valid && report.safe_entered) |-> report.safe_is_active)
        else $error("safe mode entry reported while inactive");

    assert property (@(posedge clk) disable iff (!rst_n)
        (report_valid && report.safe_exited && !report.safe_entered)
            |-> !report.safe_is_active)
        else $error("safe mode exit reported while still active");

endmodule

`default_nettype wire

@@ rtl/eres_cfg_regs.sv @@
`default_nettype none

module eres_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [eres_pkg::CFG_INDEX_W-1:0] wr_index,
    input  wire logic [eres_pkg::CFG_DATA_W-1:0]  wr_data,
    output eres_pkg::cfg_t                      cfg
);
    import eres_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.esc_control     <= RST_ESC_CONTROL;
            cfg_reg.esc_trip_level  <= RST_ESC_TRIP_LEVEL;
            cfg_reg.esc_period      <= RST_ESC_PERIOD;
            cfg_reg.esc_holdoff     <= RST_ESC_HOLDOFF;
            cfg_reg.safe_enable     <= RST_SAFE_ENABLE;
            cfg_reg.safe_trip_level <= RST_SAFE_TRIP_LEVEL;
            cfg_reg.safe_period     <= RST_SAFE_PERIOD;
            cfg_reg.safe_dwell      <= RST_SAFE_DWELL;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ESC_CONTROL:     cfg_reg.esc_control     <= wr_data[3:0];
                REG_ESC_TRIP_LEVEL:  cfg_reg.esc_trip_level  <= wr_data;
                REG_ESC_PERIOD:      cfg_reg.esc_period      <= wr_data;
                REG_ESC_HOLDOFF:     cfg_reg.esc_holdoff     <= wr_data;
                REG_SAFE_ENABLE:     cfg_reg.safe_enable     <= wr_data[0];
                REG_SAFE_TRIP_LEVEL: cfg_reg.safe_trip_level <= wr_data;
                REG_SAFE_PERIOD:     cfg_reg.safe_period     <= wr_data;
                REG_SAFE_DWELL:      cfg_reg.safe_dwell      <= wr_data;
                default:
                begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire
